>>> sv/shot_gate_heat_jam_controller_core_macros.svh
// Assertion macros for the shot gate core.
// Each macro expects clk and rst_n in scope.
`ifndef SHOT_GATE_HEAT_JAM_CONTROLLER_CORE_MACROS_SVH
`define SHOT_GATE_HEAT_JAM_CONTROLLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define SG_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("shot gate check failed");
// Next-cycle implication
`define SG_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("shot gate check failed");
`else
`define SG_ASSERT_IMP(label, cond, prop)
`define SG_ASSERT_NXT(label, cond, prop)
`endif

`endif

>>> sv/shotgate_pkg.sv
`timescale 1ns / 1ps
package shotgate_pkg;

    // Fire mode codes
    localparam logic [1:0] MODE_CONT   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_TRIPLE = 2'd2;

    // Register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_PER_SHOT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FLYWHEEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ANGLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd7;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  RST_HEAT_PER_SHOT = 8'd10;
    localparam logic [15:0] RST_FEED_STEP     = 16'd8192;
    localparam logic [9:0]  RST_MIN_FLYWHEEL  = 10'd11;
    localparam logic [14:0] RST_JAM_THRESHOLD = 15'd7777;
    localparam logic [15:0] RST_JAM_LIMIT     = 16'd111;
    localparam logic [15:0] RST_REVERSE_ANGLE = 16'd3000;
    localparam logic [15:0] RST_RECOVERY      = 16'd1000;

    // Rest times per mode
    localparam logic [9:0] REST_FREE        = 10'd100;
    localparam logic [9:0] REST_FREE_TRIPLE = 10'd600;
    localparam logic [9:0] REST_HEAT        = 10'd300;
    localparam logic [9:0] REST_HEAT_TRIPLE = 10'd900;

    localparam logic [15:0] STRAIN_MAX = 16'hFFFF;

    // Stream word widths
    localparam int unsigned IN_DATA_W  = 144;
    localparam int unsigned OUT_DATA_W = 48;

    typedef struct packed {
        logic [1:0]  fire_mode;
        logic [7:0]  heat_per_shot;
        logic [15:0] feed_step_angle;
        logic [9:0]  min_flywheel_speed;
        logic [14:0] jam_drive_threshold;
        logic [15:0] jam_count_limit;
        logic [15:0] reverse_angle;
        logic [15:0] recovery_ticks;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_tick;
        logic [15:0]        heat_level;
        logic [15:0]        heat_cap;
        logic               heat_unlimited;
        logic signed [15:0] flywheel_speed;
        logic [7:0]         fire_request;
        logic signed [31:0] feeder_angle;
        logic signed [15:0] speed_loop_out;
    } item_t;

    typedef struct packed {
        logic signed [31:0] angle_target;
        logic [7:0]         request_left;
        logic               over_heat;
        logic               jammed;
        logic               feed_stopped;
        logic               shot_issued;
    } result_t;

    // Magnitude of a signed 16-bit value
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] r;
        r = v[15] ? 16'(-v) : 16'(v);
        return r;
    endfunction

endpackage

>>> sv/shotgate_cfg.sv
`timescale 1ns / 1ps
module shotgate_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [shotgate_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [shotgate_pkg::CFG_DATA_W-1:0]  wr_data,
    output shotgate_pkg::cfg_t                   cfg
);

    shotgate_pkg::cfg_t cfg_reg;
    shotgate_pkg::cfg_t cfg_next;

    // Decode the write into the register set
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                shotgate_pkg::REG_FIRE_MODE:     cfg_next.fire_mode = wr_data[1:0];
                shotgate_pkg::REG_HEAT_PER_SHOT: cfg_next.heat_per_shot = wr_data[7:0];
                shotgate_pkg::REG_FEED_STEP:     cfg_next.feed_step_angle = wr_data;
                shotgate_pkg::REG_MIN_FLYWHEEL:  cfg_next.min_flywheel_speed = wr_data[9:0];
                shotgate_pkg::REG_JAM_THRESHOLD: cfg_next.jam_drive_threshold = wr_data[14:0];
                shotgate_pkg::REG_JAM_LIMIT:     cfg_next.jam_count_limit = wr_data;
                shotgate_pkg::REG_REVERSE_ANGLE: cfg_next.reverse_angle = wr_data;
                shotgate_pkg::REG_RECOVERY:      cfg_next.recovery_ticks = wr_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fire_mode           <= shotgate_pkg::MODE_CONT;
            cfg_reg.heat_per_shot       <= shotgate_pkg::RST_HEAT_PER_SHOT;
            cfg_reg.feed_step_angle     <= shotgate_pkg::RST_FEED_STEP;
            cfg_reg.min_flywheel_speed  <= shotgate_pkg::RST_MIN_FLYWHEEL;
            cfg_reg.jam_drive_threshold <= shotgate_pkg::RST_JAM_THRESHOLD;
            cfg_reg.jam_count_limit     <= shotgate_pkg::RST_JAM_LIMIT;
            cfg_reg.reverse_angle       <= shotgate_pkg::RST_REVERSE_ANGLE;
            cfg_reg.recovery_ticks      <= shotgate_pkg::RST_RECOVERY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/shotgate_core.sv
`timescale 1ns / 1ps
`include "shot_gate_heat_jam_controller_core_macros.svh"
module shotgate_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  shotgate_pkg::cfg_t      cfg,
    input  shotgate_pkg::item_t     item,
    output shotgate_pkg::result_t   result
);

    // Controller state
    logic [31:0] last_shot_reg, last_shot_next;
    logic [9:0]  rest_reg, rest_next;
    logic        heat_block_reg, heat_block_next;
    logic        stop_reg, stop_next;
    logic        jam_reg, jam_next;
    logic        recovering_reg, recovering_next;
    logic [15:0] strain_reg, strain_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] setpoint_reg, setpoint_next;

    logic        triple;
    logic [9:0]  heat_add;
    logic [16:0] heat_sum;
    logic [15:0] fly_mag;
    logic [15:0] drive_mag;
    logic [31:0] recover_diff;
    logic [31:0] since_shot;
    logic [17:0] step_total;
    logic [7:0]  req_next;
    logic        gate_open;
    logic        shot;

    assign triple    = (cfg.fire_mode == shotgate_pkg::MODE_TRIPLE);
    assign heat_add  = triple ? ({2'b00, cfg.heat_per_shot} + {1'b0, cfg.heat_per_shot, 1'b0})
                              : {2'b00, cfg.heat_per_shot};
    assign heat_sum  = {1'b0, item.heat_level} + {7'd0, heat_add};
    assign fly_mag   = shotgate_pkg::mag16(item.flywheel_speed);
    assign drive_mag = shotgate_pkg::mag16(item.speed_loop_out);
    assign recover_diff = item.now_tick - deadline_reg;
    assign since_shot   = item.now_tick - last_shot_reg;
    assign step_total   = triple ? ({2'b00, cfg.feed_step_angle}
                                    + {1'b0, cfg.feed_step_angle, 1'b0})
                                 : {2'b00, cfg.feed_step_angle};

    // Heat check, jam check and fire gate for one tick
    always_comb
    begin
        last_shot_next  = last_shot_reg;
        rest_next       = rest_reg;
        heat_block_next = heat_block_reg;
        stop_next       = stop_reg;
        jam_next        = jam_reg;
        recovering_next = recovering_reg;
        strain_next     = strain_reg;
        deadline_next   = deadline_reg;
        setpoint_next   = setpoint_reg;
        req_next        = item.fire_request;
        gate_open       = 1'b0;
        shot            = 1'b0;

        // Pick rest time and predict heat
        if (item.heat_unlimited)
        begin
            if (cfg.fire_mode == shotgate_pkg::MODE_CONT
                || cfg.fire_mode == shotgate_pkg::MODE_SINGLE)
                rest_next = shotgate_pkg::REST_FREE;
            else if (triple)
                rest_next = shotgate_pkg::REST_FREE_TRIPLE;
        end
        else
        begin
            if (cfg.fire_mode == shotgate_pkg::MODE_CONT
                || cfg.fire_mode == shotgate_pkg::MODE_SINGLE)
                rest_next = shotgate_pkg::REST_HEAT;
            else if (triple)
                rest_next = shotgate_pkg::REST_HEAT_TRIPLE;
            heat_block_next = (heat_sum >= {1'b0, item.heat_cap});
        end

        // Track strain, declare jam and run recovery
        if (jam_reg)
        begin
            if (recovering_reg)
            begin
                if (recover_diff != 32'd0 && !recover_diff[31])
                begin
                    jam_next        = 1'b0;
                    strain_next     = 16'd0;
                    recovering_next = 1'b0;
                end
            end
            else
            begin
                setpoint_next   = item.feeder_angle + {16'd0, cfg.reverse_angle};
                deadline_next   = item.now_tick + {16'd0, cfg.recovery_ticks};
                recovering_next = 1'b1;
            end
        end
        else if (!stop_reg)
        begin
            if (drive_mag > {1'b0, cfg.jam_drive_threshold}
                && strain_reg != shotgate_pkg::STRAIN_MAX)
                strain_next = strain_reg + 16'd1;
            if (strain_next > cfg.jam_count_limit)
                jam_next = 1'b1;
        end

        // Gate the feeder on flywheel speed, rest time, fire request and heat block
        if (fly_mag < {6'd0, cfg.min_flywheel_speed})
        begin
            stop_next     = 1'b1;
            jam_next      = 1'b0;
            setpoint_next = item.feeder_angle;
        end
        else
        begin
            stop_next = 1'b0;
            gate_open = (since_shot >= {22'd0, rest_next}) && (item.fire_request != 8'd0)
                        && !heat_block_next;
            if (gate_open)
            begin
                if (cfg.fire_mode == shotgate_pkg::MODE_CONT)
                begin
                    shot = 1'b1;
                    if (item.fire_request > 8'd1)
                        req_next = 8'd0;
                end
                else if (cfg.fire_mode == shotgate_pkg::MODE_SINGLE || triple)
                begin
                    shot     = 1'b1;
                    req_next = 8'd0;
                end
                if (shot)
                    setpoint_next = setpoint_next + {14'd0, step_total};
                last_shot_next = item.now_tick;
            end
        end
    end

    // Commit state when the tick moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_shot_reg  <= '0;
            rest_reg       <= '0;
            heat_block_reg <= 1'b0;
            stop_reg       <= 1'b0;
            jam_reg        <= 1'b0;
            recovering_reg <= 1'b0;
            strain_reg     <= '0;
            deadline_reg   <= '0;
            setpoint_reg   <= '0;
        end
        else if (advance)
        begin
            last_shot_reg  <= last_shot_next;
            rest_reg       <= rest_next;
            heat_block_reg <= heat_block_next;
            stop_reg       <= stop_next;
            jam_reg        <= jam_next;
            recovering_reg <= recovering_next;
            strain_reg     <= strain_next;
            deadline_reg   <= deadline_next;
            setpoint_reg   <= setpoint_next;
        end
    end

    assign result.angle_target = setpoint_next;
    assign result.request_left = req_next;
    assign result.over_heat    = heat_block_next;
    assign result.jammed       = jam_next || recovering_next;
    assign result.feed_stopped = stop_next;
    assign result.shot_issued  = shot;

    // A shot needs a spinning flywheel and no heat block
    `SG_ASSERT_IMP(a_shot_clear, shot, !stop_next && !heat_block_next)
    // A shot stamps its own time
    `SG_ASSERT_NXT(a_shot_time, advance && shot, last_shot_reg == $past(item.now_tick))
    // State holds while no tick moves
    `SG_ASSERT_NXT(a_hold, !advance, $stable(setpoint_reg) && $stable(strain_reg))
    // A slow flywheel follows the measured angle
    `SG_ASSERT_NXT(a_slow_follow, advance && stop_next,
                   setpoint_reg == $past(item.feeder_angle) && !jam_reg)

endmodule

>>> sv/shot_gate_heat_jam_controller_core.sv
`timescale 1ns / 1ps
// Shot gate controller: one control tick per input word, one result word per tick.
// A new word is taken every clock cycle while the output is not stalled; each result word
// passes through the input register and then the result register, with the single
// pass of heat, jam and gate logic between those registers. Controller state
// lives in the core and moves on only as a tick passes into the result register, so a
// stalled output holds the whole chain. Configuration writes take effect in the next
// cycle; cfg_ready is always high.
module shot_gate_heat_jam_controller_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // now_tick[31:0], heat_level[47:32], heat_cap[63:48], heat_unlimited[64],
    // flywheel_speed[80:65], fire_request[88:81], feeder_angle[120:89],
    // speed_loop_out[136:121], zero fill[143:137]
    input  logic [shotgate_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // angle_target[31:0], request_left[39:32], over_heat[40], jammed[41],
    // feed_stopped[42], shot_issued[43], zero fill[47:44]
    output logic [shotgate_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [shotgate_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shotgate_pkg::CFG_DATA_W-1:0]   cfg_data
);

    shotgate_pkg::cfg_t    cfg;
    shotgate_pkg::item_t   in_reg, in_next;
    shotgate_pkg::result_t result;
    shotgate_pkg::result_t out_reg;
    logic                  in_valid_reg, in_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  advance;
    logic                  s_accept;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    shotgate_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shotgate_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_reg),
        .result  (result)
    );

    // Unpack the input word
    always_comb
    begin
        in_next.now_tick       = s_tdata[31:0];
        in_next.heat_level     = s_tdata[47:32];
        in_next.heat_cap       = s_tdata[63:48];
        in_next.heat_unlimited = s_tdata[64];
        in_next.flywheel_speed = s_tdata[80:65];
        in_next.fire_request   = s_tdata[88:81];
        in_next.feeder_angle   = s_tdata[120:89];
        in_next.speed_loop_out = s_tdata[136:121];
    end

    // Valid flags of both stages
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load input and result payloads
    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_reg <= in_next;
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.shot_issued, out_reg.feed_stopped, out_reg.jammed,
                       out_reg.over_heat, out_reg.request_left, out_reg.angle_target};

endmodule

>>> bench/shot_gate_board_pkg.sv
`timescale 1ns / 1ps
package shot_gate_board_pkg;
    import shotgate_pkg::*;

    // Fire mode code left over in the two-bit register
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class shot_gate_board;
        // Register copies
        logic [1:0]  fire_mode;
        logic [7:0]  heat_per_shot;
        logic [15:0] feed_step;
        logic [9:0]  min_flywheel;
        logic [14:0] jam_threshold;
        logic [15:0] jam_limit;
        logic [15:0] back_angle;
        logic [15:0] recovery_len;

        // Controller state
        logic [31:0] last_shot;
        logic [9:0]  rest_len;
        logic        heat_block;
        logic        stop_flag;
        logic        jam_flag;
        logic        recovering;
        logic [15:0] strain;
        logic [31:0] deadline;
        logic [31:0] setpoint;

        result_t     due_words[$];
        int unsigned faults;

        function new();
            fire_mode     = MODE_CONT;
            heat_per_shot = RST_HEAT_PER_SHOT;
            feed_step     = RST_FEED_STEP;
            min_flywheel  = RST_MIN_FLYWHEEL;
            jam_threshold = RST_JAM_THRESHOLD;
            jam_limit     = RST_JAM_LIMIT;
            back_angle    = RST_REVERSE_ANGLE;
            recovery_len  = RST_RECOVERY;
            last_shot     = '0;
            rest_len      = '0;
            heat_block    = 1'b0;
            stop_flag     = 1'b0;
            jam_flag      = 1'b0;
            recovering    = 1'b0;
            strain        = '0;
            deadline      = '0;
            setpoint      = '0;
            faults        = 0;
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        // Mirror a register write, keeping only the register's own width
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FIRE_MODE:     fire_mode     = val[1:0];
                REG_HEAT_PER_SHOT: heat_per_shot = val[7:0];
                REG_FEED_STEP:     feed_step     = val;
                REG_MIN_FLYWHEEL:  min_flywheel  = val[9:0];
                REG_JAM_THRESHOLD: jam_threshold = val[14:0];
                REG_JAM_LIMIT:     jam_limit     = val;
                REG_REVERSE_ANGLE: back_angle    = val;
                REG_RECOVERY:      recovery_len  = val;
                default: ;
            endcase
        endfunction

        function int unsigned magnitude(logic signed [15:0] v);
            int s;
            s = int'(v);
            return unsigned'((s < 0) ? -s : s);
        endfunction

        // Advance the controller by one tick and queue the result word it gives
        function void note_tick(item_t t);
            int unsigned fly_mag;
            int unsigned drive_mag;
            int unsigned heat_sum;
            logic [31:0] gap;
            logic [7:0]  req;
            result_t     r;
            fly_mag   = magnitude(t.flywheel_speed);
            drive_mag = magnitude(t.speed_loop_out);
            req       = t.fire_request;
            r         = '0;

            // Rest time and heat prediction
            if (t.heat_unlimited)
            begin
                case (fire_mode)
                    MODE_CONT, MODE_SINGLE: rest_len = REST_FREE;
                    MODE_TRIPLE:            rest_len = REST_FREE_TRIPLE;
                    default: ;
                endcase
            end
            else
            begin
                heat_sum = int'(t.heat_level)
                         + int'(heat_per_shot) * ((fire_mode == MODE_TRIPLE) ? 3 : 1);
                case (fire_mode)
                    MODE_CONT, MODE_SINGLE: rest_len = REST_HEAT;
                    MODE_TRIPLE:            rest_len = REST_HEAT_TRIPLE;
                    default: ;
                endcase
                heat_block = (heat_sum >= int'(t.heat_cap));
            end

            // Jam detection and recovery, seeing last tick's stop flag
            if (jam_flag)
            begin
                if (recovering)
                begin
                    gap = t.now_tick - deadline;
                    if (gap != 0 && !gap[31])
                    begin
                        jam_flag   = 1'b0;
                        strain     = '0;
                        recovering = 1'b0;
                    end
                end
                else
                begin
                    setpoint   = t.feeder_angle + 32'(back_angle);
                    deadline   = t.now_tick + 32'(recovery_len);
                    recovering = 1'b1;
                end
            end
            else if (!stop_flag)
            begin
                if (drive_mag > int'(jam_threshold) && strain != STRAIN_MAX)
                    strain = strain + 16'd1;
                if (strain > jam_limit)
                    jam_flag = 1'b1;
            end

            // Feed gate
            if (fly_mag < int'(min_flywheel))
            begin
                stop_flag = 1'b1;
                jam_flag  = 1'b0;
                setpoint  = t.feeder_angle;
            end
            else
            begin
                stop_flag = 1'b0;
                gap = t.now_tick - last_shot;
                if (gap >= 32'(rest_len) && req != 0 && !heat_block)
                begin
                    case (fire_mode)
                        MODE_CONT:
                        begin
                            setpoint = setpoint + 32'(feed_step);
                            if (req > 8'd1)
                                req = '0;
                            r.shot_issued = 1'b1;
                        end
                        MODE_SINGLE:
                        begin
                            setpoint = setpoint + 32'(feed_step);
                            req = '0;
                            r.shot_issued = 1'b1;
                        end
                        MODE_TRIPLE:
                        begin
                            setpoint = setpoint + 32'(feed_step) * 32'd3;
                            req = '0;
                            r.shot_issued = 1'b1;
                        end
                        default: ;
                    endcase
                    last_shot = t.now_tick;
                end
            end

            r.angle_target = setpoint;
            r.request_left = req;
            r.over_heat    = heat_block;
            r.jammed       = jam_flag || recovering;
            r.feed_stopped = stop_flag;
            due_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                faults++;
                $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Check one result word against the oldest expectation
        function void check_word(logic [OUT_DATA_W-1:0] w);
            result_t want;
            if (due_words.size() == 0)
            begin
                faults++;
                $display("%0t ns: result word expected none actual %h", $time, w);
                return;
            end
            want = due_words.pop_front();
            compare_field("angle_target", want.angle_target, w[31:0]);
            compare_field("request_left", 32'(want.request_left), 32'(w[39:32]));
            compare_field("over_heat", 32'(want.over_heat), 32'(w[40]));
            compare_field("jammed", 32'(want.jammed), 32'(w[41]));
            compare_field("feed_stopped", 32'(want.feed_stopped), 32'(w[42]));
            compare_field("shot_issued", 32'(want.shot_issued), 32'(w[43]));
        endfunction
    endclass

endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import shotgate_pkg::*;
    import shot_gate_board_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    shot_gate_board board;
    logic        steady;
    logic        hold_sink;
    logic [31:0] clock_now;

    shot_gate_heat_jam_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_sink = 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 31);
        end
    end

    // Check every result word taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata);
    end

    function automatic logic [IN_DATA_W-1:0] pack_tick(item_t t);
        return {7'd0, t.speed_loop_out, t.feeder_angle, t.fire_request, t.flywheel_speed,
                t.heat_unlimited, t.heat_cap, t.heat_level, t.now_tick};
    endfunction

    function automatic item_t make_tick(logic [31:0] now, logic [15:0] heat, logic [15:0] cap,
                                        logic unl, logic [15:0] fly, logic [7:0] req,
                                        logic [31:0] angle, logic [15:0] drive);
        item_t t;
        t.now_tick       = now;
        t.heat_level     = heat;
        t.heat_cap       = cap;
        t.heat_unlimited = unl;
        t.flywheel_speed = fly;
        t.fire_request   = req;
        t.feeder_angle   = angle;
        t.speed_loop_out = drive;
        return t;
    endfunction

    function automatic logic [15:0] with_sign(int unsigned m);
        return $urandom_range(0, 1) ? 16'(0 - m) : 16'(m);
    endfunction

    // Random tick with time mostly moving forward in rest-sized steps
    function automatic item_t random_tick();
        item_t       t;
        int unsigned roll;
        int unsigned lim;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            clock_now = $urandom;
        else if (roll < 7)
            clock_now = clock_now - $urandom_range(0, 2000);
        else
            clock_now = clock_now + $urandom_range(0, 700);
        t.now_tick = clock_now;

        if ($urandom_range(0, 4) == 0)
        begin
            t.heat_level = 16'($urandom);
            t.heat_cap   = 16'($urandom);
        end
        else
        begin
            t.heat_cap   = 16'($urandom_range(0, 2000));
            t.heat_level = 16'($urandom_range(0, 2000));
        end
        t.heat_unlimited = ($urandom_range(0, 3) == 0);

        lim  = 32'(board.min_flywheel);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            t.flywheel_speed = with_sign($urandom_range(0, lim));
        else if (roll < 12)
            t.flywheel_speed = 16'($urandom);
        else
            t.flywheel_speed = with_sign($urandom_range(lim, 32767));

        roll = $urandom_range(0, 99);
        if (roll < 30)
            t.fire_request = '0;
        else if (roll < 60)
            t.fire_request = 8'd1;
        else
            t.fire_request = 8'($urandom);

        t.feeder_angle = $urandom;
        lim = 32'(board.jam_threshold);
        if ($urandom_range(0, 1) && lim < 32767)
            t.speed_loop_out = with_sign($urandom_range(lim + 1, 32767));
        else
            t.speed_loop_out = 16'($urandom);
        return t;
    endfunction

    // Random tick with a nonzero speed loop output, to build up strain
    function automatic item_t strain_tick();
        item_t t;
        t = random_tick();
        t.speed_loop_out = with_sign($urandom_range(1, 32767));
        return t;
    endfunction

    // Offer one tick word and wait for it to be taken
    task automatic push_tick(input item_t t);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= pack_tick(t);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_tick(t);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input int unsigned mode, input int unsigned hps,
                              input int unsigned step, input int unsigned minfly,
                              input int unsigned thr, input int unsigned limit,
                              input int unsigned rev, input int unsigned rec);
        write_reg(REG_FIRE_MODE, 16'(mode));
        write_reg(REG_HEAT_PER_SHOT, 16'(hps));
        write_reg(REG_FEED_STEP, 16'(step));
        write_reg(REG_MIN_FLYWHEEL, 16'(minfly));
        write_reg(REG_JAM_THRESHOLD, 16'(thr));
        write_reg(REG_JAM_LIMIT, 16'(limit));
        write_reg(REG_REVERSE_ANGLE, 16'(rev));
        write_reg(REG_RECOVERY, 16'(rec));
    endtask

    initial
    begin
        int p;
        int n;
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        hold_sink = 1'b0;
        clock_now = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks on reset settings: field extremes, heat edge, slow flywheel,
        // strain seen only after a running tick, time wrap
        push_tick(make_tick(0, 0, 16'hFFFF, 0, 1000, 1, 0, 0));
        push_tick(make_tick(300, 0, 16'hFFFF, 0, 32767, 2, 100, 0));
        push_tick(make_tick(350, 0, 16'hFFFF, 0, 500, 255, 0, 0));
        push_tick(make_tick(700, 16'hFFFF, 16'hFFFF, 0, 500, 1, 0, 0));
        push_tick(make_tick(1100, 0, 0, 0, 500, 1, 0, 0));
        push_tick(make_tick(1500, 0, 0, 1, 500, 1, 0, 0));
        push_tick(make_tick(1600, 0, 11, 0, 500, 1, 0, 0));
        push_tick(make_tick(1700, 0, 11, 0, 16'(-32768), 3, 0, 0));
        push_tick(make_tick(2000, 0, 1000, 0, 10, 1, 32'h7FFF_FFFF, 32767));
        push_tick(make_tick(2100, 0, 1000, 0, 16'(-11), 1, 32'h8000_0000, 32767));
        push_tick(make_tick(2200, 0, 1000, 0, 0, 1, 32'h8000_0000, 16'(-32768)));
        push_tick(make_tick(2300, 0, 1000, 0, 11, 1, 0, 16'(-32768)));
        push_tick(make_tick(2400, 0, 1000, 0, 11, 1, 0, 32767));
        push_tick(make_tick(2500, 0, 1000, 0, 11, 1, 0, 7777));
        push_tick(make_tick(2600, 0, 1000, 0, 11, 1, 0, 16'(-7778)));
        push_tick(make_tick(32'hFFFF_FFFF, 0, 1000, 0, 500, 1, 32'hFFFF_FFFF, 0));
        push_tick(make_tick(10, 0, 1000, 0, 500, 1, 0, 0));
        push_tick(make_tick(400, 0, 1000, 0, 500, 0, 0, 0));
        push_tick(make_tick(800, 0, 0, 1, 500, 255, 0, 0));
        push_tick(make_tick(1200, 990, 1000, 0, 500, 1, 0, 0));
        push_tick(make_tick(1600, 0, 16'hFFFF, 1, 16'(-32767), 254, 0, 0));
        drain_results();
        clock_now = 32'd5000;

        // Random phases, each under its own register setting
        for (p = 0; p < 12; p++)
        begin
            case (p)
                0: load_setup(32'(MODE_SINGLE), 255, 65535, 1000, 32767, 0, 65535, 65535);
                1: load_setup(32'(MODE_CONT), 0, 0, 0, 0, 0, 0, 0);
                2: load_setup(32'(MODE_TRIPLE), 20, 1000, 50, 3000, 5, 500, 150);
                3: load_setup(32'(MODE_UNUSED), 30, 4000, 200, 6000, 3, 700, 80);
                4: load_setup(32'(MODE_TRIPLE), 255, 65535, 11, 100, 10, 65535, 300);
                default:
                    load_setup($urandom, $urandom, $urandom,
                               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1023),
                               $urandom_range(0, 1) ? $urandom_range(0, 9000) : $urandom,
                               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30),
                               $urandom,
                               $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom);
            endcase
            steady = (p == 5);
            for (n = 0; n < 155; n++)
            begin
                push_tick(random_tick());
                // Hold the result side off long enough to back up the input
                if (p == 3 && n == 40)
                    hold_sink = 1'b1;
            end
            drain_results();
        end
        steady = 1'b0;

        // Build up strain under a high limit, then lower the limit under it
        load_setup(32'(MODE_CONT), 10, 8192, 0, 0, 65535, 100, 20);
        for (n = 0; n < 30; n++)
            push_tick(strain_tick());
        drain_results();
        write_reg(REG_JAM_LIMIT, 16'd20);
        for (n = 0; n < 30; n++)
            push_tick(random_tick());
        drain_results();

        repeat (10) @(posedge clk);
        if (board.faults == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
